// ===== rtl/vde_pkg.sv =====
package vde_pkg;

   localparam int MaxLen = 4096;
   localparam int CountWidth = $clog2(MaxLen + 1);

   localparam int MainWidth = 46;
   localparam int NormWidth = 43;

   // metric codes
   localparam logic [1:0] MetricEuclid = 2'd0;
   localparam logic [1:0] MetricManhat = 2'd1;
   localparam logic [1:0] MetricCosine = 2'd2;

   // error codes
   localparam logic [1:0] ErrNone = 2'd0;
   localparam logic [1:0] ErrZeroNorm = 2'd1;
   localparam logic [1:0] ErrTooLong = 2'd2;

   // finished sums handed from the front end to the back end
   typedef struct packed {
      logic [1:0]                  metric;
      logic signed [MainWidth-1:0] main_sum;
      logic [NormWidth-1:0]        norm_p;
      logic [NormWidth-1:0]        norm_q;
      logic                        overflow;
   } sums_type;

   localparam int SumsWidth = $bits(sums_type);

endpackage

// ===== rtl/vde_front.sv =====
module vde_front (
   input  logic               clock,
   input  logic               reset,
   input  logic [1:0]         metric,
   input  logic               in_valid,
   output logic               in_ready,
   input  logic signed [15:0] p_value,
   input  logic signed [15:0] q_value,
   input  logic               last,
   output logic               sums_valid,
   input  logic               sums_ready,
   output vde_pkg::sums_type  sums
);
   import vde_pkg::*;

   logic signed [MainWidth-1:0] main_ff, main_in;
   logic [NormWidth-1:0]        np_ff, np_in, nq_ff, nq_in;
   logic [CountWidth-1:0]       count_ff, count_in;
   logic                        ovf_ff, ovf_in;
   logic signed [16:0]          diff;
   logic signed [33:0]          term;
   logic                        take, full;

   // stall while the finished-sums slot is occupied and not drained
   assign in_ready = !sums_valid || sums_ready;
   assign take = in_valid && in_ready;
   assign full = (count_ff >= CountWidth'(MaxLen));
   assign diff = 17'(q_value) - 17'(p_value);

   // per-element term of the current metric
   always_comb begin
      case (metric)
         MetricManhat: term = diff[16] ? 34'(-diff) : 34'(diff);
         MetricCosine: term = 34'(p_value * q_value);
         default:      term = 34'(diff * diff);
      endcase
   end

   // accumulate, saturating the element count
   always_comb begin
      main_in = main_ff;
      np_in = np_ff;
      nq_in = nq_ff;
      count_in = count_ff;
      ovf_in = ovf_ff;
      if (full) begin
         ovf_in = 1'b1;
      end else begin
         main_in = main_ff + MainWidth'(term);
         np_in = np_ff + NormWidth'(32'(p_value * p_value));
         nq_in = nq_ff + NormWidth'(32'(q_value * q_value));
         count_in = count_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_ff <= '0;
         np_ff <= '0;
         nq_ff <= '0;
         count_ff <= '0;
         ovf_ff <= 1'b0;
         sums_valid <= 1'b0;
      end else begin
         if (sums_valid && sums_ready) sums_valid <= 1'b0;
         if (take) begin
            if (last) begin
               sums <= '{metric, main_in, np_in, nq_in, ovf_in};
               sums_valid <= 1'b1;
               main_ff <= '0;
               np_ff <= '0;
               nq_ff <= '0;
               count_ff <= '0;
               ovf_ff <= 1'b0;
            end else begin
               main_ff <= main_in;
               np_ff <= np_in;
               nq_ff <= nq_in;
               count_ff <= count_in;
               ovf_ff <= ovf_in;
            end
         end
      end
   end

endmodule

// ===== rtl/vde_back.sv =====
module vde_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              sums_valid,
   output logic              sums_ready,
   input  vde_pkg::sums_type sums,
   output logic              out_valid,
   input  logic              out_ready,
   output logic [31:0]       result_value,
   output logic [1:0]        error_code
);
   import vde_pkg::*;

   typedef enum logic [6:0] {
      S_IDLE = 7'b0000001,
      S_SQRT = 7'b0000010,
      S_MULA = 7'b0000100,
      S_MULB = 7'b0001000,
      S_DIV  = 7'b0010000,
      S_FIN  = 7'b0100000,
      S_OUT  = 7'b1000000
   } state_type;

   state_type state_ff;
   sums_type  job_ff;

   // two shared-step square roots over 60-bit radicands (2 bits a cycle)
   logic [59:0] xa_ff, xb_ff, ra_ff, rb_ff, ba_ff, bb_ff;
   logic [59:0] xa_in, xb_in, ra_in, rb_in;
   logic [59:0] rad_a, rad_b;
   logic [4:0]  step_ff;
   logic [63:0] den_ff;
   logic [31:0] cross_ff;
   logic [45:0] mag_ff;
   logic [5:0]  div_ff;
   logic [64:0] rem_ff;
   logic [46:0] quo_ff;
   logic        neg_ff;
   logic [64:0] rem_sh;
   logic [45:0] s_pos;
   logic [31:0] res_ff;
   logic [1:0]  code_ff;
   logic        zero_norm;

   assign sums_ready = (state_ff == S_IDLE);
   assign out_valid = (state_ff == S_OUT);
   assign result_value = res_ff;
   assign error_code = code_ff;
   assign s_pos = job_ff.main_sum[45] ? '0 : job_ff.main_sum;
   assign zero_norm = (job_ff.norm_p == '0) || (job_ff.norm_q == '0);

   // one digit of each root
   always_comb begin
      xa_in = xa_ff;
      ra_in = ra_ff >> 1;
      if (xa_ff >= ra_ff + ba_ff) begin
         xa_in = xa_ff - (ra_ff + ba_ff);
         ra_in = (ra_ff >> 1) + ba_ff;
      end
      xb_in = xb_ff;
      rb_in = rb_ff >> 1;
      if (xb_ff >= rb_ff + bb_ff) begin
         xb_in = xb_ff - (rb_ff + bb_ff);
         rb_in = (rb_ff >> 1) + bb_ff;
      end
   end

   assign rem_sh = {rem_ff[63:0], 1'b0};

   // pick radicands: euclid/manhattan use main sum, cosine the norms
   always_comb begin
      rad_a = {job_ff.norm_p, 16'd0} ;
      rad_b = {job_ff.norm_q, 16'd0};
      if (job_ff.metric != MetricCosine) rad_a = {s_pos[43:0], 16'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         case (state_ff)
            S_IDLE: begin
               if (sums_valid) begin
                  job_ff <= sums;
                  step_ff <= 5'd0;
                  // fall into root setup in the next cycle
                  state_ff <= S_SQRT;
               end
            end
            S_SQRT: begin
               if (step_ff == 5'd0) begin
                  xa_ff <= rad_a;
                  xb_ff <= rad_b;
                  ra_ff <= '0;
                  rb_ff <= '0;
                  ba_ff <= 60'd1 << 58;
                  bb_ff <= 60'd1 << 58;
                  step_ff <= 5'd1;
               end else begin
                  xa_ff <= xa_in;
                  xb_ff <= xb_in;
                  ra_ff <= ra_in;
                  rb_ff <= rb_in;
                  ba_ff <= ba_ff >> 2;
                  bb_ff <= bb_ff >> 2;
                  step_ff <= step_ff + 5'd1;
                  if (step_ff == 5'd30) begin
                     state_ff <= (job_ff.metric == MetricCosine) ? S_MULA : S_FIN;
                  end
               end
            end
            S_MULA: begin
               // roots fit in 32 bits: split 32x32 into one 16x32 and two 16x16 partials
               cross_ff <= 32'(ra_ff[31:16] * rb_ff[31:16]);
               den_ff <= 64'(ra_ff[15:0] * rb_ff[31:0]);
               state_ff <= S_MULB;
            end
            S_MULB: begin
               den_ff <= den_ff + ({32'd0, 32'(ra_ff[31:16] * rb_ff[15:0])} << 16)
                  + ({32'd0, cross_ff} << 32);
               neg_ff <= job_ff.main_sum[45];
               mag_ff <= job_ff.main_sum[45] ? 46'(-job_ff.main_sum)
                  : 46'(job_ff.main_sum);
               state_ff <= S_DIV;
               div_ff <= 6'd0;
            end
            S_DIV: begin
               if (div_ff == 6'd0) begin
                  quo_ff <= '0;
                  rem_ff <= {19'd0, mag_ff};
                  div_ff <= 6'd1;
                  if (zero_norm || {19'd0, mag_ff} >= {1'b0, den_ff}) begin
                     state_ff <= S_FIN;
                     quo_ff <= 47'd1 << 30;
                  end
               end else begin
                  if (rem_sh >= {1'b0, den_ff}) begin
                     rem_ff <= rem_sh - {1'b0, den_ff};
                     quo_ff <= {quo_ff[45:0], 1'b1};
                  end else begin
                     rem_ff <= rem_sh;
                     quo_ff <= {quo_ff[45:0], 1'b0};
                  end
                  div_ff <= div_ff + 6'd1;
                  if (div_ff == 6'd46) state_ff <= S_FIN;
               end
            end
            S_FIN: begin
               code_ff <= job_ff.overflow ? ErrTooLong : ErrNone;
               case (job_ff.metric)
                  MetricManhat:
                     res_ff <= (s_pos > 46'h7FFF_FFFF) ? 32'h7FFF_FFFF : s_pos[31:0];
                  MetricCosine: begin
                     if (zero_norm) begin
                        res_ff <= '0;
                        code_ff <= ErrZeroNorm;
                     end else if (quo_ff > (47'd1 << 30)) begin
                        res_ff <= neg_ff ? -(32'd1 << 30) : (32'd1 << 30);
                     end else begin
                        res_ff <= neg_ff ? -quo_ff[31:0] : quo_ff[31:0];
                     end
                  end
                  default:
                     res_ff <= (ra_ff > 60'h7FFF_FFFF) ? 32'h7FFF_FFFF : ra_ff[31:0];
               endcase
               state_ff <= S_OUT;
            end
            S_OUT: if (out_ready) state_ff <= S_IDLE;
            default: state_ff <= S_IDLE;
         endcase
      end
   end

endmodule

// ===== rtl/vector_distance_engine.sv =====
// vector distance engine
// req channel: one word per element pair, tdata = {q_value, p_value},
// no tuser; tlast marks the final pair of the vectors.
// rsp channel: one word per vector, tdata = result_value, tuser = error_code.
// csr_we/csr_wdata write the metric (0 euclid, 1 manhattan, 2 cosine);
// write it only while the engine is idle.
// the front end takes one pair per cycle while req_tready is high and
// accumulates the sums; on tlast the sums move to a one-entry slot read by
// the back end. the back end runs two shift-subtract square roots (one load
// plus 30 steps), and for cosine a split multiply in S_MULA and S_MULB and
// a 46-step restoring divide, which stops early when a norm is zero or the
// ratio clamps. the back end takes the next vector the cycle after its word
// is accepted. pairs keep streaming meanwhile unless a second finished vector
// is waiting, then req_tready drops.
// reset clears the running sums, the metric (to euclid) and both handshakes.
// a stalled rsp holds its word; the back end waits, and the front end
// fills the slot and then stalls.
module vector_distance_engine (
   input  logic        clock,
   input  logic        reset,
   input  logic        csr_we,
   input  logic [1:0]  csr_wdata,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [31:0] req_tdata,   // p_value, q_value
   input  logic        req_tlast,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // result_value
   output logic [1:0]  rsp_tuser    // error_code
);
   import vde_pkg::*;

   logic [1:0] metric_ff;
   logic       sums_valid, sums_ready;
   sums_type   sums;

   // metric register
   always_ff @(posedge clock) begin
      if (reset) metric_ff <= MetricEuclid;
      else if (csr_we) metric_ff <= csr_wdata;
   end

   vde_front u_front (
      .clock(clock), .reset(reset), .metric(metric_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .p_value(req_tdata[15:0]), .q_value(req_tdata[31:16]), .last(req_tlast),
      .sums_valid(sums_valid), .sums_ready(sums_ready), .sums(sums)
   );

   vde_back u_back (
      .clock(clock), .reset(reset),
      .sums_valid(sums_valid), .sums_ready(sums_ready), .sums(sums),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .result_value(rsp_tdata), .error_code(rsp_tuser)
   );

`ifndef SYNTH
   a_code_range: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tuser != 2'd3) else $error("bad error code");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result dropped under stall");
   a_slot_stall: assert property (@(posedge clock) disable iff (reset)
      sums_valid && !sums_ready |-> !req_tready) else $error("slot overrun");
`endif

endmodule
